// File: src/mwo_pkg.sv
package mwo_pkg;

	localparam int SINE_DEPTH = 256;
	localparam int SINE_AW = $clog2(SINE_DEPTH);
	localparam int IDX_W = SINE_AW + 2;
	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_MODE = '0;

	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef enum logic [2:0] {
		WAVE_SINE = 3'd0,
		WAVE_COSINE = 3'd1,
		WAVE_TRIANGLE = 3'd2,
		WAVE_SAW = 3'd3,
		WAVE_REV_SAW = 3'd4,
		WAVE_PULSE = 3'd5,
		WAVE_SQUARE = 3'd6
	} wave_mode_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} pipe_ctrl_t;

	typedef logic [15:0] sine_lut_t [0:SINE_DEPTH];

	function automatic sine_lut_t build_sine_lut();
		sine_lut_t lut;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		logic [63:0] s;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x = (Q30_HALF_PI * 64'(k)) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			acc = Q30_ONE;
			for (int n = 0; n < 6; n++) begin
				acc = Q30_ONE - (((x2 * acc) >> 30) / TAYLOR_DIV[n]);
			end
			s = (x * acc) >> 30;
			s = (s + 64'd16384) >> 15;
			if (s > 64'd32768) begin
				s = 64'd32768;
			end
			lut[k] = s[15:0];
		end
		return lut;
	endfunction

endpackage

// File: src/multi_waveform_oscillator.sv
// Each item passes through the input register, the phase multiply register and the
// result register in turn.
// Throughput: one item per cycle while out_stall is low; each stage takes a new item
// when enabled. A bubble in any stage is filled even while the output is stalled.
// Reset clears the sample counter, the waveform mode (sine) and all stage valids.
module multi_waveform_oscillator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [31:0]                 phase_step,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [15:0]          wave_value,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mwo_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import mwo_pkg::*;

	pipe_ctrl_t  ctrl;
	logic        valid_s1;
	logic        valid_s2;
	logic        valid_s3;
	logic [2:0]  mode;
	logic [31:0] phase_s2;
	logic [31:0] step_s2;
	logic [15:0] wave_s3;

	always_comb begin
		ctrl.en3 = !valid_s3 || !out_stall;
		ctrl.en2 = !valid_s2 || ctrl.en3;
		ctrl.en1 = !valid_s1 || ctrl.en2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ctrl.en1) begin
				valid_s1 <= in_valid;
			end
			if (ctrl.en2) begin
				valid_s2 <= valid_s1;
			end
			if (ctrl.en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	mwo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	mwo_phase u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.in_valid   (in_valid),
		.phase_step (phase_step),
		.phase_s2   (phase_s2),
		.step_s2    (step_s2)
	);

	mwo_shape u_shape (
		.clk      (clk),
		.ctrl     (ctrl),
		.mode     (mode),
		.phase_s2 (phase_s2),
		.step_s2  (step_s2),
		.wave_s3  (wave_s3)
	);

	assign in_stall = !ctrl.en1;
	assign out_valid = valid_s3;
	assign wave_value = signed'(wave_s3);

endmodule

// File: src/mwo_regs.sv
module mwo_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mwo_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [2:0]                  mode
);
	import mwo_pkg::*;

	logic [2:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= WAVE_SINE;
		end else if (psel && penable && pwrite && paddr == ADDR_MODE) begin
			mode_q <= pwdata[2:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MODE) ? {29'd0, mode_q} : 32'd0;
	assign mode = mode_q;

endmodule

// File: src/mwo_phase.sv
module mwo_phase (
	input  logic                clk,
	input  logic                arst_n,
	input  mwo_pkg::pipe_ctrl_t ctrl,
	input  logic                in_valid,
	input  logic [31:0]         phase_step,
	output logic [31:0]         phase_s2,
	output logic [31:0]         step_s2
);
	import mwo_pkg::*;

	logic [31:0] count_q;
	logic [31:0] count_s1;
	logic [31:0] step_s1;
	logic [31:0] product;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.en1 && in_valid) begin
			count_q <= count_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			count_s1 <= count_q;
			step_s1 <= phase_step;
		end
	end

	assign product = count_s1 * step_s1;

	always_ff @(posedge clk) begin
		if (ctrl.en2) begin
			phase_s2 <= product;
			step_s2 <= step_s1;
		end
	end

endmodule

// File: src/mwo_shape.sv
module mwo_shape (
	input  logic                clk,
	input  mwo_pkg::pipe_ctrl_t ctrl,
	input  logic [2:0]          mode,
	input  logic [31:0]         phase_s2,
	input  logic [31:0]         step_s2,
	output logic [15:0]         wave_s3
);
	import mwo_pkg::*;

	localparam sine_lut_t SINE_LUT = build_sine_lut();

	logic [IDX_W-1:0]   idx;
	logic [1:0]         quad;
	logic [SINE_AW-1:0] off;
	logic [SINE_AW:0]   lut_addr;
	logic [15:0]        mag;
	logic [15:0]        sine_val;
	logic [31:0]        tri_c;
	logic [16:0]        tri_fall;
	logic [16:0]        rev_val;
	logic [32:0]        wrap_sum;
	logic [15:0]        wave_d;

	always_comb begin
		idx = phase_s2[31 -: IDX_W];
		off = idx[SINE_AW-1:0];
		quad = idx[IDX_W-1 -: 2];
		if (wave_mode_t'(mode) == WAVE_COSINE) begin
			quad = quad + 2'd1;
		end
		if (!quad[0]) begin
			lut_addr = {1'b0, off};
		end else begin
			lut_addr = (SINE_AW+1)'(SINE_DEPTH) - {1'b0, off};
		end
		mag = SINE_LUT[lut_addr];
		if (!quad[1]) begin
			sine_val = mag[15] ? 16'h7FFF : mag;
		end else begin
			sine_val = ~mag + 16'd1;
		end

		tri_c = phase_s2 - 32'h4000_0000;
		tri_fall = 17'h08000 - {2'b00, tri_c[30:16]};
		rev_val = 17'h08000 - {1'b0, phase_s2[31:16]};
		wrap_sum = {1'b0, phase_s2} + {1'b0, step_s2};

		case (wave_mode_t'(mode))
			WAVE_SINE, WAVE_COSINE: wave_d = sine_val;
			WAVE_TRIANGLE: begin
				if (!tri_c[31]) begin
					wave_d = {1'b1, tri_c[30:16]};
				end else if (tri_c[30:16] == '0) begin
					wave_d = 16'h7FFF;
				end else begin
					wave_d = tri_fall[15:0];
				end
			end
			WAVE_SAW: wave_d = phase_s2[31:16] ^ 16'h8000;
			WAVE_REV_SAW: begin
				if (phase_s2[31:16] == '0) begin
					wave_d = 16'h7FFF;
				end else begin
					wave_d = rev_val[15:0];
				end
			end
			WAVE_PULSE: wave_d = wrap_sum[32] ? 16'h7FFF : 16'h0000;
			WAVE_SQUARE: wave_d = phase_s2[31] ? 16'h8000 : 16'h7FFF;
			default: wave_d = 16'h0000;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en3) begin
			wave_s3 <= wave_d;
		end
	end

endmodule
